// File: rtl/core/i2cmbe_pkg.sv
// Package for the I2C master byte engine: command codes, shared constants,
// and the sequencer state and input record types. It depends on nothing else.
`default_nettype none

package i2cmbe_pkg;

  localparam int unsigned BitsPerByte = 8;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_e;

  typedef enum logic [0:0] {
    REG_TICKS_PER_US = 1'd0,
    REG_ACK_TIMEOUT  = 1'd1
  } reg_idx_e;

  localparam logic [7:0] TicksPerUsReset = 8'd50;
  localparam logic [7:0] AckTimeoutReset = 8'd250;

  typedef struct packed {
    logic [7:0] ticks_per_us;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    cmd_e       active;
    logic [3:0] phase;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic [9:0] delay_count;
    logic [7:0] poll_count;
    logic       scl;
    logic       sda;
    logic       error;
    logic       ack_choice;
    logic [7:0] rx_hold;
    logic       done;
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cmbe_if.sv
// Handshake channel interfaces of the I2C master byte engine: command input,
// pin result output and configuration write. They depend on nothing else.
`default_nettype none

interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_sample;

  modport source (output valid, cmd, tx_byte, send_ack, sda_sample, input ready);
  modport sink (input valid, cmd, tx_byte, send_ack, sda_sample, output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_failed, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                ack_failed, output ready);
endinterface

interface i2cmbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/i2cmbe_step.sv
// Next-state logic of the I2C master byte engine for one tick: command start,
// delay countdown, phase advance and ack polling. It depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_step (
  input  i2cmbe_pkg::state_t cur_i,
  input  i2cmbe_pkg::item_t  item_i,
  input  i2cmbe_pkg::cfg_t   cfg_i,
  output i2cmbe_pkg::state_t nxt_o
);
  import i2cmbe_pkg::*;

  function automatic logic [9:0] load_delay(logic [7:0] tpu, logic [1:0] sh);
    logic [7:0] t;
    t = (tpu == 8'd0) ? 8'd1 : tpu;
    return ({2'b00, t} << sh) - 10'd1;
  endfunction

  function automatic state_t finish_f(state_t s);
    if (s.active == CMD_READ) begin
      s.rx_hold = s.shift_byte;
    end
    s.active = CMD_NONE;
    s.phase  = 4'd0;
    s.done   = 1'b1;
    return s;
  endfunction

  function automatic state_t enter_f(state_t s, logic [3:0] ph, logic sda, logic [7:0] tpu);
    s.phase = ph;
    case (s.active)
      CMD_START: begin
        if (ph == 4'd0) begin
          s.sda = 1'b1;
          s.scl = 1'b1;
        end else begin
          s.sda = 1'b0;
        end
        s.delay_count = load_delay(tpu, 2'd2);
      end
      CMD_STOP: begin
        s.scl = (ph != 4'd0);
        s.sda = (ph != 4'd0);
        s.delay_count = load_delay(tpu, 2'd2);
      end
      CMD_WRITE: begin
        if (ph == 4'd0) begin
          s.scl = 1'b0;
          s.sda = s.shift_byte[BitsPerByte-1];
        end else begin
          s.scl = (ph == 4'd1);
        end
        s.delay_count = load_delay(tpu, 2'd1);
      end
      CMD_READ: begin
        if (ph == 4'd0) begin
          s.scl = 1'b0;
          s.sda = 1'b1;
          s.delay_count = load_delay(tpu, 2'd1);
        end else if (ph == 4'd1) begin
          s.scl = 1'b1;
          s.shift_byte = {s.shift_byte[BitsPerByte-2:0], sda};
          s.delay_count = load_delay(tpu, 2'd0);
        end else if (ph == 4'd2) begin
          s.scl = 1'b0;
          s.sda = ~s.ack_choice;
          s.delay_count = load_delay(tpu, 2'd1);
        end else begin
          s.scl = 1'b1;
          s.delay_count = load_delay(tpu, 2'd1);
        end
      end
      CMD_WAIT_ACK: begin
        if (ph == 4'd0) begin
          s.sda = 1'b1;
          s.scl = 1'b1;
          s.delay_count = load_delay(tpu, 2'd0);
        end else if (ph == 4'd1) begin
          s.scl = 1'b1;
          s.delay_count = load_delay(tpu, 2'd0);
        end else if (ph == 4'd2) begin
          s.delay_count = 10'd0;
        end else if (ph == 4'd3) begin
          s.scl = 1'b0;
          s.sda = 1'b0;
          s.delay_count = load_delay(tpu, 2'd2);
        end else begin
          s.scl = 1'b1;
          s.sda = 1'b1;
          s.delay_count = load_delay(tpu, 2'd2);
        end
      end
      default: begin
        s = finish_f(s);
      end
    endcase
    return s;
  endfunction

  function automatic state_t advance_f(state_t s, logic sda, logic [7:0] tpu);
    case (s.active)
      CMD_START: begin
        if (s.phase == 4'd0) begin
          s = enter_f(s, 4'd1, sda, tpu);
        end else begin
          s.scl = 1'b0;
          s = finish_f(s);
        end
      end
      CMD_STOP: begin
        if (s.phase == 4'd0) begin
          s = enter_f(s, 4'd1, sda, tpu);
        end else begin
          s = finish_f(s);
        end
      end
      CMD_WRITE: begin
        if (s.phase < 4'd2) begin
          s = enter_f(s, s.phase + 4'd1, sda, tpu);
        end else begin
          s.shift_byte = {s.shift_byte[BitsPerByte-2:0], 1'b0};
          s.bit_index  = s.bit_index + 4'd1;
          if (s.bit_index < 4'(BitsPerByte)) begin
            s = enter_f(s, 4'd0, sda, tpu);
          end else begin
            s = finish_f(s);
          end
        end
      end
      CMD_READ: begin
        if (s.phase == 4'd0) begin
          s = enter_f(s, 4'd1, sda, tpu);
        end else if (s.phase == 4'd1) begin
          s.bit_index = s.bit_index + 4'd1;
          if (s.bit_index < 4'(BitsPerByte)) begin
            s = enter_f(s, 4'd0, sda, tpu);
          end else begin
            s = enter_f(s, 4'd2, sda, tpu);
          end
        end else if (s.phase == 4'd2) begin
          s = enter_f(s, 4'd3, sda, tpu);
        end else begin
          s.scl = 1'b0;
          s = finish_f(s);
        end
      end
      CMD_WAIT_ACK: begin
        if (s.phase == 4'd0) begin
          s = enter_f(s, 4'd1, sda, tpu);
        end else if (s.phase == 4'd1) begin
          s = enter_f(s, 4'd2, sda, tpu);
        end else if (s.phase == 4'd3) begin
          s = enter_f(s, 4'd4, sda, tpu);
        end else begin
          s = finish_f(s);
        end
      end
      default: begin
        s = finish_f(s);
      end
    endcase
    return s;
  endfunction

  always_comb begin
    state_t s;
    s = cur_i;
    s.done = 1'b0;
    if (s.active == CMD_NONE) begin
      if (item_i.cmd inside {[CMD_START:CMD_WAIT_ACK]}) begin
        s.active     = cmd_e'(item_i.cmd);
        s.bit_index  = 4'd0;
        s.poll_count = 8'd0;
        if (s.active == CMD_WRITE) begin
          s.shift_byte = item_i.tx_byte;
        end
        if (s.active == CMD_READ) begin
          s.shift_byte = 8'd0;
          s.ack_choice = item_i.send_ack;
        end
        if (s.active == CMD_WAIT_ACK) begin
          s.error = 1'b0;
        end
        s = enter_f(s, 4'd0, item_i.sda_sample, cfg_i.ticks_per_us);
      end
    end else if (s.active == CMD_WAIT_ACK && s.phase == 4'd2) begin
      if (!item_i.sda_sample) begin
        s.scl = 1'b0;
        s = finish_f(s);
      end else if (s.poll_count >= cfg_i.ack_timeout) begin
        s.error = 1'b1;
        s = enter_f(s, 4'd3, item_i.sda_sample, cfg_i.ticks_per_us);
      end else begin
        s.poll_count = s.poll_count + 8'd1;
      end
    end else if (s.delay_count != 10'd0) begin
      s.delay_count = s.delay_count - 10'd1;
    end else begin
      s = advance_f(s, item_i.sda_sample, cfg_i.ticks_per_us);
    end
    nxt_o = s;
  end

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_byte_engine_core.sv
// I2C master byte engine, top level. Each transfer on the input channel is one
// bus tick carrying an optional command and the sampled SDA level; each tick
// yields exactly one result transfer with the SCL and SDA levels to drive, busy,
// a one-tick done pulse, the last read byte and the ack-wait error. The engine
// takes one input transfer per clock cycle: the sequencer state advances on the
// accepting edge and the result lands in an output register, and input ready is
// high whenever that register is empty or being drained in the same cycle.
// Configuration writes are taken at any time and should be made while idle.
// Depends on i2cmbe_pkg, the channel interfaces in i2cmbe_if and i2cmbe_step.
`default_nettype none

module i2c_master_byte_engine_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  i2cmbe_in_if.sink        in_i,
  i2cmbe_out_if.source     out_o,
  i2cmbe_cfg_if.sink       cfg_i
);
  import i2cmbe_pkg::*;

  cfg_t   cfg_q;
  state_t st_q;
  state_t st_d;
  item_t  item;
  logic   in_acc;
  logic   out_valid_q;
  logic   scl_q;
  logic   sda_q;
  logic   busy_q;
  logic   done_q;
  logic [7:0] rx_q;
  logic   err_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us <= TicksPerUsReset;
      cfg_q.ack_timeout  <= AckTimeoutReset;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_i.data;
        REG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_i.data;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  assign item.cmd        = in_i.cmd;
  assign item.tx_byte    = in_i.tx_byte;
  assign item.send_ack   = in_i.send_ack;
  assign item.sda_sample = in_i.sda_sample;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  i2cmbe_step u_step (
    .cur_i  (st_q),
    .item_i (item),
    .cfg_i  (cfg_q),
    .nxt_o  (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{active: CMD_NONE, phase: 4'd0, bit_index: 4'd0, shift_byte: 8'd0,
                delay_count: 10'd0, poll_count: 8'd0, scl: 1'b1, sda: 1'b1,
                error: 1'b0, ack_choice: 1'b0, rx_hold: 8'd0, done: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scl_q  <= st_d.scl;
      sda_q  <= st_d.sda;
      busy_q <= (st_d.active != CMD_NONE);
      done_q <= st_d.done;
      rx_q   <= st_d.rx_hold;
      err_q  <= st_d.error;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.scl_level  = scl_q;
  assign out_o.sda_level  = sda_q;
  assign out_o.busy_res   = busy_q;
  assign out_o.done_res   = done_q;
  assign out_o.rx_byte    = rx_q;
  assign out_o.ack_failed = err_q;

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("Accepted tick produced no result.");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(done_q && busy_q))
    else $error("Result shows done while still busy.");

  a_idle_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.active == CMD_NONE) |-> (st_q.phase == 4'd0))
    else $error("Idle sequencer holds a nonzero phase.");

  a_done_means_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.done |-> (st_q.active == CMD_NONE))
    else $error("Done flagged while a command is active.");

  a_poll_no_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.active == CMD_WAIT_ACK && st_q.phase == 4'd2) |-> (st_q.delay_count == 10'd0))
    else $error("Ack polling phase with a pending delay.");
`endif

endmodule

`default_nettype wire

// File: tb/sv/i2cmbe_checker.sv
// Scoreboard for the I2C master byte engine: watches the command, result and
// configuration channels, predicts every result transfer and compares it.
// Depends on i2cmbe_pkg and the channel interfaces in i2cmbe_if.
`timescale 1ns / 1ps

module i2cmbe_checker
  import i2cmbe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  i2cmbe_in_if  cmd_i,
  i2cmbe_out_if res_i,
  i2cmbe_cfg_if cfg_i,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       fail;
  } pins_t;

  logic [7:0] us_ticks;
  logic [7:0] ack_limit;

  logic [2:0] cur_cmd;
  logic [3:0] cur_phase;
  logic [3:0] bit_cnt;
  logic [7:0] shift_q;
  logic [9:0] delay_q;
  logic [7:0] poll_q;
  logic       scl_q;
  logic       sda_q;
  logic       err_q;
  logic       ack_q;
  logic [7:0] rx_q;
  logic       done_q;

  pins_t pin_q[$];
  pins_t got;
  pins_t want;
  int    fails;

  function automatic void engine_reset();
    us_ticks  = TicksPerUsReset;
    ack_limit = AckTimeoutReset;
    cur_cmd   = CMD_NONE;
    cur_phase = '0;
    bit_cnt   = '0;
    shift_q   = '0;
    delay_q   = '0;
    poll_q    = '0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    err_q     = 1'b0;
    ack_q     = 1'b0;
    rx_q      = '0;
    done_q    = 1'b0;
  endfunction

  function automatic void set_delay(input int unsigned us);
    logic [31:0] span;
    span = us * ((us_ticks == 8'd0) ? 32'd1 : {24'd0, us_ticks}) - 32'd1;
    delay_q = span[9:0];
  endfunction

  function automatic void cmd_finish();
    if (cur_cmd == CMD_READ) rx_q = shift_q;
    cur_cmd   = CMD_NONE;
    cur_phase = '0;
    done_q    = 1'b1;
  endfunction

  function automatic void phase_entry(input logic [3:0] ph, input logic s);
    cur_phase = ph;
    case (cur_cmd)
      CMD_START: begin
        if (ph == 4'd0) begin
          sda_q = 1'b1;
          scl_q = 1'b1;
        end else begin
          sda_q = 1'b0;
        end
        set_delay(4);
      end
      CMD_STOP: begin
        scl_q = (ph != 4'd0);
        sda_q = (ph != 4'd0);
        set_delay(4);
      end
      CMD_WRITE: begin
        if (ph == 4'd0) begin
          scl_q = 1'b0;
          sda_q = shift_q[BitsPerByte-1];
        end else begin
          scl_q = (ph == 4'd1);
        end
        set_delay(2);
      end
      CMD_READ: begin
        case (ph)
          4'd0: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            set_delay(2);
          end
          4'd1: begin
            scl_q = 1'b1;
            shift_q = {shift_q[6:0], s};
            set_delay(1);
          end
          4'd2: begin
            scl_q = 1'b0;
            sda_q = !ack_q;
            set_delay(2);
          end
          default: begin
            scl_q = 1'b1;
            set_delay(2);
          end
        endcase
      end
      CMD_WAIT_ACK: begin
        case (ph)
          4'd0: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
            set_delay(1);
          end
          4'd1: begin
            scl_q = 1'b1;
            set_delay(1);
          end
          4'd2: begin
            delay_q = '0;
          end
          4'd3: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
            set_delay(4);
          end
          default: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            set_delay(4);
          end
        endcase
      end
      default: cmd_finish();
    endcase
  endfunction

  function automatic void phase_done(input logic s);
    case (cur_cmd)
      CMD_START: begin
        if (cur_phase == 4'd0) begin
          phase_entry(4'd1, s);
        end else begin
          scl_q = 1'b0;
          cmd_finish();
        end
      end
      CMD_STOP: begin
        if (cur_phase == 4'd0) phase_entry(4'd1, s);
        else cmd_finish();
      end
      CMD_WRITE: begin
        if (cur_phase < 4'd2) begin
          phase_entry(cur_phase + 4'd1, s);
        end else begin
          shift_q = shift_q << 1;
          bit_cnt++;
          if (bit_cnt < BitsPerByte) phase_entry(4'd0, s);
          else cmd_finish();
        end
      end
      CMD_READ: begin
        if (cur_phase == 4'd0) begin
          phase_entry(4'd1, s);
        end else if (cur_phase == 4'd1) begin
          bit_cnt++;
          if (bit_cnt < BitsPerByte) phase_entry(4'd0, s);
          else phase_entry(4'd2, s);
        end else if (cur_phase == 4'd2) begin
          phase_entry(4'd3, s);
        end else begin
          scl_q = 1'b0;
          cmd_finish();
        end
      end
      CMD_WAIT_ACK: begin
        if (cur_phase == 4'd0) phase_entry(4'd1, s);
        else if (cur_phase == 4'd1) phase_entry(4'd2, s);
        else if (cur_phase == 4'd3) phase_entry(4'd4, s);
        else cmd_finish();
      end
      default: cmd_finish();
    endcase
  endfunction

  function automatic pins_t bus_tick(input logic [2:0] c, input logic [7:0] tx,
                                     input logic ack, input logic s);
    pins_t pins;
    done_q = 1'b0;
    if (cur_cmd == CMD_NONE) begin
      if (c >= CMD_START && c <= CMD_WAIT_ACK) begin
        cur_cmd = c;
        bit_cnt = '0;
        poll_q  = '0;
        if (c == CMD_WRITE) shift_q = tx;
        if (c == CMD_READ) begin
          shift_q = '0;
          ack_q   = ack;
        end
        if (c == CMD_WAIT_ACK) err_q = 1'b0;
        phase_entry(4'd0, s);
      end
    end else if (cur_cmd == CMD_WAIT_ACK && cur_phase == 4'd2) begin
      if (!s) begin
        scl_q = 1'b0;
        cmd_finish();
      end else if (poll_q >= ack_limit) begin
        err_q = 1'b1;
        phase_entry(4'd3, s);
      end else begin
        poll_q++;
      end
    end else if (delay_q != '0) begin
      delay_q--;
    end else begin
      phase_done(s);
    end
    pins.scl  = scl_q;
    pins.sda  = sda_q;
    pins.busy = (cur_cmd != CMD_NONE);
    pins.done = done_q;
    pins.rx   = rx_q;
    pins.fail = err_q;
    return pins;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      engine_reset();
      pin_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.scl  = res_i.scl_level;
        got.sda  = res_i.sda_level;
        got.busy = res_i.busy_res;
        got.done = res_i.done_res;
        got.rx   = res_i.rx_byte;
        got.fail = res_i.ack_failed;
        if (pin_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: result transfer with nothing expected", $realtime);
        end else begin
          want = pin_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch exp scl=%b sda=%b busy=%b done=%b rx=%h fail=%b",
                       $realtime, want.scl, want.sda, want.busy, want.done, want.rx,
                       want.fail);
              $display("%0t:          got scl=%b sda=%b busy=%b done=%b rx=%h fail=%b",
                       $realtime, got.scl, got.sda, got.busy, got.done, got.rx, got.fail);
            end
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_TICKS_PER_US) us_ticks = cfg_i.data;
        else ack_limit = cfg_i.data;
      end
      if (cmd_i.valid && cmd_i.ready) begin
        pin_q.push_back(bus_tick(cmd_i.cmd, cmd_i.tx_byte, cmd_i.send_ack,
                                 cmd_i.sda_sample));
      end
      fail_count_o <= fails;
      pending_o <= pin_q.size();
    end
  end

endmodule

// File: tb/sv/i2c_master_byte_engine_core_test.sv
// Top of the I2C master byte engine testbench: clock, reset, command stimulus
// with bursty input and stalling output, configuration phases and the verdict.
// Depends on i2cmbe_pkg, i2cmbe_if, the engine core and i2cmbe_checker.
`timescale 1ns / 1ps

module i2c_master_byte_engine_core_test;
  import i2cmbe_pkg::*;

  localparam int CycleLimit = 100_000;
  localparam int ItemTarget = 500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  i2cmbe_in_if  in_if ();
  i2cmbe_out_if out_if ();
  i2cmbe_cfg_if cfg_if ();

  int          fail_count;
  int          pending;
  int          done_cnt = 0;
  int          sent_cnt = 0;
  logic        last_busy = 1'b0;
  int          burst_left = 0;
  int          sda_low_pct = 50;
  bit          junk_on = 1'b0;
  logic [15:0] stall_pat = '0;
  int          pat_age = 0;

  i2c_master_byte_engine_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  i2cmbe_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (in_if),
    .res_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (pat_age == 63) begin
      pat_age <= 0;
      stall_pat <= ($urandom_range(3) == 0) ? 16'h0000
                                             : (16'($urandom_range(65535)) & 16'hFEFE);
    end else begin
      pat_age <= pat_age + 1;
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    out_if.ready <= !stall_pat[0];
  end

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      done_cnt <= done_cnt + out_if.done_res;
      last_busy <= out_if.busy_res;
    end
    if (in_if.valid && in_if.ready) begin
      sent_cnt <= sent_cnt + 1;
    end
  end

  task automatic drive_tick(input logic [2:0] c, input logic [7:0] tx, input logic ack);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.cmd <= c;
    in_if.tx_byte <= tx;
    in_if.send_ack <= ack;
    in_if.sda_sample <= ($urandom_range(99) < sda_low_pct) ? 1'b0 : 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic issue(input logic [2:0] c, input logic [7:0] tx, input logic ack,
                       input int low_pct);
    int done_mark;
    sda_low_pct = low_pct;
    done_mark = done_cnt;
    drive_tick(c, tx, ack);
    while (done_cnt == done_mark) begin
      if (junk_on && $urandom_range(19) == 0)
        drive_tick(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        drive_tick(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic issue_rand(input logic [2:0] c);
    int pct;
    pct = 50;
    if (c == CMD_WAIT_ACK) begin
      case ($urandom_range(2))
        0: pct = 0;
        1: pct = 3;
        default: pct = 30;
      endcase
    end
    issue(c, 8'($urandom_range(255)), 1'($urandom_range(1)), pct);
  endtask

  task automatic run_random(input int upto);
    logic [2:0] c;
    while (sent_cnt < upto) begin
      c = 3'($urandom_range(7));
      if (c >= CMD_START && c <= CMD_WAIT_ACK) begin
        issue_rand(c);
      end else begin
        sda_low_pct = 50;
        drive_tick(c, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic go_idle();
    do begin
      sda_low_pct = 50;
      while (last_busy) drive_tick(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      in_if.valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end while (last_busy);
  endtask

  task automatic set_timing(input logic [7:0] tpu, input logic [7:0] ato);
    go_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_TICKS_PER_US;
    cfg_if.data <= tpu;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= REG_ACK_TIMEOUT;
    cfg_if.data <= ato;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.cmd <= CMD_NONE;
    in_if.tx_byte <= '0;
    in_if.send_ack <= 1'b0;
    in_if.sda_sample <= 1'b1;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_TICKS_PER_US;
    cfg_if.data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_tick(3'd6, 8'hFF, 1'b1);
    drive_tick(3'd7, 8'h00, 1'b0);
    drive_tick(CMD_NONE, 8'h5A, 1'b1);

    set_timing(8'd0, 8'd0);
    issue(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    issue(CMD_START, 8'h00, 1'b0, 50);

    set_timing(8'd1, 8'd1);
    issue(CMD_START, 8'h00, 1'b0, 50);
    issue(CMD_WRITE, 8'hA5, 1'b0, 50);
    issue(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    issue(CMD_WRITE, 8'h00, 1'b1, 50);
    issue(CMD_WAIT_ACK, 8'hFF, 1'b1, 100);
    issue(CMD_READ, 8'hFF, 1'b1, 0);
    issue(CMD_READ, 8'h00, 1'b0, 100);
    issue(CMD_STOP, 8'h00, 1'b0, 50);
    repeat (4) drive_tick(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));

    junk_on = 1'b1;
    set_timing(8'd2, 8'd3);
    issue_rand(CMD_START);
    issue_rand(CMD_READ);
    issue_rand(CMD_STOP);
    set_timing(8'($urandom_range(1, 2)), 8'($urandom_range(0, 3)));
    run_random(ItemTarget);

    go_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/i2cmbe_pkg.sv
rtl/core/i2cmbe_if.sv
rtl/core/i2cmbe_step.sv
rtl/core/i2c_master_byte_engine_core.sv
tb/sv/i2cmbe_checker.sv
tb/sv/i2c_master_byte_engine_core_test.sv
